// ===== rtl/vrme_pkg.sv =====
// Package for the version rolling midstate engine.
// Holds SHA-256 constants, round helpers and the controller state type.
// No dependencies.
package vrme_pkg;

    localparam int VARIANTS_DEF = 4;
    localparam int SLOTS = 15;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_EMIT,
        ST_NEXT
    } ctrl_state_t;

    typedef struct packed {
        logic start_job;    // latch versions from the input word
        logic init_variant; // load window and working vars
        logic do_round;     // one compression round
        logic emit_word;    // output word taken, advance position
        logic next_variant;
    } dp_cmd_t;

    typedef struct packed {
        logic last_round;
        logic last_pos;
        logic last_variant;
    } dp_stat_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== rtl/vrme_if.sv =====
// Valid/ready channel interfaces for the midstate engine.
// Depends on nothing.
interface vrme_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  word_slot;
    logic [31:0] word_value;
    logic [31:0] ver_base;
    logic [31:0] roll_mask;
    modport source (output valid, action, word_slot, word_value, ver_base,
                    roll_mask, input ready);
    modport sink (input valid, action, word_slot, word_value, ver_base,
                  roll_mask, output ready);
endinterface

interface vrme_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  variant_number;
    logic [31:0] rolled_version;
    logic [2:0]  state_position;
    logic [31:0] state_word;
    logic        final_word;
    modport source (output valid, variant_number, rolled_version, state_position,
                    state_word, final_word, input ready);
    modport sink (input valid, variant_number, rolled_version, state_position,
                  state_word, final_word, output ready);
endinterface

// ===== rtl/vrme_ctrl.sv =====
// Controller state machine for the midstate engine.
// Depends on vrme_pkg.
module vrme_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_action,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vrme_pkg::dp_cmd_t     cmd,
    input  vrme_pkg::dp_stat_t    stat
);

    vrme_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrme_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vrme_pkg::ST_IDLE:
            begin
                if (in_valid && in_action == vrme_pkg::ACT_COMPUTE)
                begin
                    state_next = vrme_pkg::ST_INIT;
                end
            end
            vrme_pkg::ST_INIT:  state_next = vrme_pkg::ST_ROUND;
            vrme_pkg::ST_ROUND:
            begin
                if (stat.last_round)
                begin
                    state_next = vrme_pkg::ST_EMIT;
                end
            end
            vrme_pkg::ST_EMIT:
            begin
                if (out_ready && stat.last_pos)
                begin
                    state_next = stat.last_variant ? vrme_pkg::ST_IDLE : vrme_pkg::ST_NEXT;
                end
            end
            vrme_pkg::ST_NEXT:  state_next = vrme_pkg::ST_INIT;
            default:            state_next = vrme_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            vrme_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.start_job = in_valid && in_action == vrme_pkg::ACT_COMPUTE;
            end
            vrme_pkg::ST_INIT:  cmd.init_variant = 1'b1;
            vrme_pkg::ST_ROUND: cmd.do_round = 1'b1;
            vrme_pkg::ST_EMIT:
            begin
                out_valid     = 1'b1;
                cmd.emit_word = out_ready;
            end
            vrme_pkg::ST_NEXT:  cmd.next_variant = 1'b1;
            default:            cmd = '0;
        endcase
    end

endmodule

// ===== rtl/vrme_dp.sv =====
// Datapath: message store, variant versions, schedule window and rounds.
// Depends on vrme_pkg.
module vrme_dp #(
    parameter int VARIANTS = vrme_pkg::VARIANTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rolling_en,
    input  logic               load_en,
    input  logic [3:0]         word_slot,
    input  logic [31:0]        word_value,
    input  logic [31:0]        ver_base,
    input  logic [31:0]        roll_mask,
    input  vrme_pkg::dp_cmd_t  cmd,
    output vrme_pkg::dp_stat_t stat,
    output logic [1:0]         variant_number,
    output logic [31:0]        rolled_version,
    output logic [2:0]         state_position,
    output logic [31:0]        state_word,
    output logic               final_word
);

    localparam int VW = $clog2(VARIANTS);

    logic [31:0]   msg_reg [vrme_pkg::SLOTS];
    logic [31:0]   ver_reg [VARIANTS];
    logic [31:0]   win_reg [16];
    logic [31:0]   wv_reg  [8];
    logic [5:0]    rnd_reg;
    logic [VW-1:0] var_reg;
    logic [VW-1:0] last_var_reg;
    logic [2:0]    pos_reg;

    // lowest nonzero nibble of the mask
    logic [31:0] low_nib;
    always_comb
    begin
        low_nib = {28'd0, roll_mask[31:28]};
        low_nib = low_nib << 28;
        for (int i = 6; i >= 0; i--)
        begin
            if (roll_mask[i*4 +: 4] != 4'd0)
            begin
                low_nib = ({28'd0, roll_mask[i*4 +: 4] & vrme_pkg::NIBBLE_MASK}) << (i*4);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && word_slot != 4'hf)
        begin
            msg_reg[word_slot] <= word_value;
        end
    end

    // schedule and round logic
    logic [31:0] w, w15, w2, s0, s1, t1, t2, a, e;
    always_comb
    begin
        w15 = win_reg[1];
        w2  = win_reg[14];
        s0  = vrme_pkg::rotr(w15, 7) ^ vrme_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1  = vrme_pkg::rotr(w2, 17) ^ vrme_pkg::rotr(w2, 19) ^ (w2 >> 10);
        w   = (rnd_reg < 6'd16) ? win_reg[0] : win_reg[0] + s0 + win_reg[9] + s1;
        a   = wv_reg[0];
        e   = wv_reg[4];
        t1  = wv_reg[7] + (vrme_pkg::rotr(e, 6) ^ vrme_pkg::rotr(e, 11) ^ vrme_pkg::rotr(e, 25))
            + ((e & wv_reg[5]) ^ (~e & wv_reg[6])) + vrme_pkg::ROUND_K[rnd_reg] + w;
        t2  = (vrme_pkg::rotr(a, 2) ^ vrme_pkg::rotr(a, 13) ^ vrme_pkg::rotr(a, 22))
            + ((a & wv_reg[1]) ^ (a & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg      <= '0;
            var_reg      <= '0;
            last_var_reg <= '0;
            pos_reg      <= '0;
            for (int i = 0; i < VARIANTS; i++) ver_reg[i] <= '0;
            for (int i = 0; i < 16; i++) win_reg[i] <= '0;
            for (int i = 0; i < 8; i++) wv_reg[i] <= '0;
        end
        else
        begin
            if (cmd.start_job)
            begin
                ver_reg[0] <= ver_base;
                var_reg    <= '0;
                if (rolling_en && roll_mask != 32'd0)
                begin
                    ver_reg[1]   <= ver_base | low_nib;
                    ver_reg[2]   <= ver_base | (roll_mask - low_nib);
                    ver_reg[3]   <= ver_base | roll_mask;
                    last_var_reg <= VW'(VARIANTS - 1);
                end
                else
                begin
                    last_var_reg <= '0;
                end
            end
            if (cmd.init_variant)
            begin
                win_reg[0] <= vrme_pkg::bswap(ver_reg[var_reg]);
                for (int i = 0; i < vrme_pkg::SLOTS; i++) win_reg[i+1] <= msg_reg[i];
                for (int i = 0; i < 8; i++) wv_reg[i] <= vrme_pkg::INIT_H[i];
                rnd_reg <= '0;
                pos_reg <= '0;
            end
            if (cmd.do_round)
            begin
                // rotate the window so the current word is always at slot 0
                for (int i = 0; i < 15; i++) win_reg[i] <= win_reg[i+1];
                win_reg[15] <= w;
                rnd_reg     <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    // last round: fold in the initial value
                    wv_reg[0] <= vrme_pkg::INIT_H[0] + t1 + t2;
                    wv_reg[1] <= vrme_pkg::INIT_H[1] + wv_reg[0];
                    wv_reg[2] <= vrme_pkg::INIT_H[2] + wv_reg[1];
                    wv_reg[3] <= vrme_pkg::INIT_H[3] + wv_reg[2];
                    wv_reg[4] <= vrme_pkg::INIT_H[4] + wv_reg[3] + t1;
                    wv_reg[5] <= vrme_pkg::INIT_H[5] + wv_reg[4];
                    wv_reg[6] <= vrme_pkg::INIT_H[6] + wv_reg[5];
                    wv_reg[7] <= vrme_pkg::INIT_H[7] + wv_reg[6];
                end
                else
                begin
                    wv_reg[7] <= wv_reg[6];
                    wv_reg[6] <= wv_reg[5];
                    wv_reg[5] <= wv_reg[4];
                    wv_reg[4] <= wv_reg[3] + t1;
                    wv_reg[3] <= wv_reg[2];
                    wv_reg[2] <= wv_reg[1];
                    wv_reg[1] <= wv_reg[0];
                    wv_reg[0] <= t1 + t2;
                end
            end
            if (cmd.emit_word)
            begin
                pos_reg <= pos_reg + 3'd1;
            end
            if (cmd.next_variant)
            begin
                var_reg <= var_reg + VW'(1);
            end
        end
    end

    // last_round, last_pos, last_variant
    assign stat = {rnd_reg == 6'd63, pos_reg == 3'd7, var_reg == last_var_reg};

    assign variant_number = 2'(var_reg);
    assign rolled_version = ver_reg[var_reg];
    assign state_position = pos_reg;
    assign state_word     = wv_reg[pos_reg];
    assign final_word     = stat.last_pos && stat.last_variant;

endmodule

// ===== rtl/version_rolling_midstate_engine_unit.sv =====
// Top level of the version rolling SHA-256 midstate engine.
// Depends on vrme_pkg, vrme_if, vrme_ctrl and vrme_dp.
//
// Usage: the input channel takes words of two kinds. A load word (action 0)
// writes one of the 15 header message words into the store; slot 15 is
// dropped. A compute word (action 1) forms one version, or four when rolling
// is enabled and the mask is nonzero, and for each runs one SHA-256
// compression: a setup step, 64 rounds, 8 output words and a step between
// variants. The single shared round unit handles the variants in turn. Input
// ready is low for the whole job. Output words are presented from the result
// registers; a receiver stall holds the current word until taken. Reset
// clears the controller and the working registers; the message store must be
// loaded before a compute. The rolling enable is written through
// cfg_we/cfg_data; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module version_rolling_midstate_engine_unit #(
    parameter int VARIANTS = vrme_pkg::VARIANTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    vrme_in_if.sink     in_ch,
    vrme_out_if.source  out_ch
);

    logic               mode_reg;
    vrme_pkg::dp_cmd_t  cmd;
    vrme_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    vrme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    vrme_dp #(.VARIANTS(VARIANTS)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .rolling_en     (mode_reg),
        .load_en        (in_ch.valid && in_ch.ready && in_ch.action == vrme_pkg::ACT_LOAD),
        .word_slot      (in_ch.word_slot),
        .word_value     (in_ch.word_value),
        .ver_base       (in_ch.ver_base),
        .roll_mask      (in_ch.roll_mask),
        .cmd            (cmd),
        .stat           (stat),
        .variant_number (out_ch.variant_number),
        .rolled_version (out_ch.rolled_version),
        .state_position (out_ch.state_position),
        .state_word     (out_ch.state_word),
        .final_word     (out_ch.final_word)
    );

endmodule
